FILE: sv/assert_macros.svh
// Assertion helpers for the RTL files (included by rbsi_top).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define RBSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RBSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rbsi_pkg.sv
package rbsi_pkg;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BOX_MIN_X = 3'd0;
  localparam cfg_idx_t CFG_BOX_MIN_Y = 3'd1;
  localparam cfg_idx_t CFG_BOX_MIN_Z = 3'd2;
  localparam cfg_idx_t CFG_BOX_MAX_X = 3'd3;
  localparam cfg_idx_t CFG_BOX_MAX_Y = 3'd4;
  localparam cfg_idx_t CFG_BOX_MAX_Z = 3'd5;

endpackage

FILE: sv/rbsi_top.sv
// Ray against axis-aligned box, slab method, signed fixed point.
// Configuration: write cfg_data to register cfg_index when cfg_we is high;
// indexes 0 to 5 are box min x, y, z and box max x, y, z. Write only while idle.
// Input channel: ray origin and direction; one transfer per cycle when
// in_valid is high and in_stall is low.
// Output channel: out_is_hit and out_entry_t (zero on a miss), one result per
// ray, in order, transferred when out_valid is high and out_stall is low.
// The six quotient units are pipelined restoring dividers that retire one
// quotient bit per stage, followed by ordering, interval reduction and the
// output register. The pipeline takes one ray per cycle unless the output
// stalls.
// A stall on the output while out_valid is high holds the whole pipeline;
// in_stall is raised in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and the box registers to zero.
module ray_box_slab_intersect_top
  import rbsi_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  cfg_idx_t                      cfg_index,
  input  logic signed [VALUE_WIDTH-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_origin_x,
  input  logic signed [VALUE_WIDTH-1:0] in_origin_y,
  input  logic signed [VALUE_WIDTH-1:0] in_origin_z,
  input  logic signed [VALUE_WIDTH-1:0] in_dir_x,
  input  logic signed [VALUE_WIDTH-1:0] in_dir_y,
  input  logic signed [VALUE_WIDTH-1:0] in_dir_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_hit,
  output logic signed [VALUE_WIDTH-1:0] out_entry_t
);

  `include "assert_macros.svh"

  localparam int VW = VALUE_WIDTH;
  localparam int DL = VW + 3;

  logic signed [VW-1:0] lo_r [3];
  logic signed [VW-1:0] hi_r [3];
  logic signed [VW-1:0] org [3];
  logic signed [VW-1:0] dir [3];
  logic signed [VW-1:0] q0 [3];
  logic signed [VW-1:0] q1 [3];
  logic signed [VW-1:0] t0_r [3];
  logic signed [VW-1:0] t1_r [3];
  logic signed [VW-1:0] tin_r, tout_r, tin01, tout01;
  logic signed [VW-1:0] out_entry_t_r;
  logic                 vld_r [0:DL-1];
  logic                 ord_v_r, red_v_r, out_valid_r, out_is_hit_r;
  logic                 adv;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= '0;
        hi_r[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_MIN_X: lo_r[0] <= cfg_data;
        CFG_BOX_MIN_Y: lo_r[1] <= cfg_data;
        CFG_BOX_MIN_Z: lo_r[2] <= cfg_data;
        CFG_BOX_MAX_X: hi_r[0] <= cfg_data;
        CFG_BOX_MAX_Y: hi_r[1] <= cfg_data;
        CFG_BOX_MAX_Z: hi_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div #(.VW(VW), .FB(FRAC_BITS)) u_div_lo (
      .clk(clk), .en(adv), .face(lo_r[a]), .org(org[a]), .dir(dir[a]), .q(q0[a])
    );
    rbsi_div #(.VW(VW), .FB(FRAC_BITS)) u_div_hi (
      .clk(clk), .en(adv), .face(hi_r[a]), .org(org[a]), .dir(dir[a]), .q(q1[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) vld_r[i] <= 1'b0;
      ord_v_r     <= 1'b0;
      red_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < DL; i++) vld_r[i] <= vld_r[i-1];
      ord_v_r     <= vld_r[DL-1];
      red_v_r     <= ord_v_r;
      out_valid_r <= red_v_r;
    end
  end

  always_comb begin
    tin01  = (t0_r[0] > t0_r[1]) ? t0_r[0] : t0_r[1];
    tout01 = (t1_r[0] < t1_r[1]) ? t1_r[0] : t1_r[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        t0_r[a] <= (q0[a] > q1[a]) ? q1[a] : q0[a];
        t1_r[a] <= (q0[a] > q1[a]) ? q0[a] : q1[a];
      end
      tin_r         <= (tin01 > t0_r[2]) ? tin01 : t0_r[2];
      tout_r        <= (tout01 < t1_r[2]) ? tout01 : t1_r[2];
      out_is_hit_r  <= (tin_r <= tout_r);
      out_entry_t_r <= (tin_r <= tout_r) ? tin_r : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_is_hit  = out_is_hit_r;
  assign out_entry_t = out_entry_t_r;

  `RBSI_ASSERT(a_miss_zero, out_valid_r && !out_is_hit_r |-> out_entry_t_r == '0, "miss with nonzero entry")
  `RBSI_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid_r && !vld_r[0], "valid survived reset")
  `RBSI_ASSERT(a_freeze, !adv |=> vld_r[0] == $past(vld_r[0]) && red_v_r == $past(red_v_r), "pipeline moved while stalled")

endmodule

FILE: sv/rbsi_div.sv
module rbsi_div
  import rbsi_pkg::*;
#(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] face,
  input  logic signed [VW-1:0] org,
  input  logic signed [VW-1:0] dir,
  output logic signed [VW-1:0] q
);

  localparam int NW = VW + 1;
  localparam int QW = VW - 1;
  localparam int CW = 2 * VW + FB + 1;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic signed [NW-1:0] num_r;
  logic signed [VW-1:0] dir_r;
  logic [NW-1:0]        an_r;
  logic [VW-1:0]        ad_r;
  logic                 negq_a_r, negn_a_r, dz_a_r;

  logic [CW-1:0] rem_r  [0:QW];
  logic [QW-1:0] qb_r   [0:QW];
  logic [VW-1:0] ad_p_r [0:QW];
  logic          sat_r  [0:QW];
  logic          sneg_r [0:QW];
  logic          negq_r [0:QW];
  logic signed [VW-1:0] q_r;

  logic [CW-1:0] rem0_nxt;
  logic          ovf_nxt;

  always_comb begin
    rem0_nxt = CW'(an_r) << FB;
    ovf_nxt  = rem0_nxt >= (CW'(ad_r) << (VW - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r    <= NW'(face) - NW'(org);
      dir_r    <= dir;
      an_r     <= num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
      ad_r     <= dir_r[VW-1] ? VW'(-dir_r) : VW'(dir_r);
      negn_a_r <= num_r[NW-1];
      negq_a_r <= num_r[NW-1] ^ dir_r[VW-1];
      dz_a_r   <= (dir_r == '0);
      rem_r[0]  <= rem0_nxt;
      qb_r[0]   <= '0;
      ad_p_r[0] <= ad_r;
      sat_r[0]  <= dz_a_r | ovf_nxt;
      sneg_r[0] <= dz_a_r ? negn_a_r : negq_a_r;
      negq_r[0] <= negq_a_r;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int K = QW - 1 - i;
    logic [CW-1:0] dv;
    logic          ge;
    always_comb begin
      dv = CW'(ad_p_r[i]) << K;
      ge = rem_r[i] >= dv;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= ge ? rem_r[i] - dv : rem_r[i];
        qb_r[i+1]   <= {qb_r[i][QW-2:0], ge};
        ad_p_r[i+1] <= ad_p_r[i];
        sat_r[i+1]  <= sat_r[i];
        sneg_r[i+1] <= sneg_r[i];
        negq_r[i+1] <= negq_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sat_r[QW]) begin
        q_r <= sneg_r[QW] ? VMIN : VMAX;
      end else if (negq_r[QW]) begin
        q_r <= -$signed({1'b0, qb_r[QW]});
      end else begin
        q_r <= $signed({1'b0, qb_r[QW]});
      end
    end
  end

  assign q = q_r;

endmodule
